// ===== hw/rtl/salsa_pkg.sv =====
// Shared types, constants and functions of the Salsa20 stream cipher.
// Used by every module of the block; depends on nothing else.
package salsa_pkg;

    localparam int ROUNDS      = 8;
    localparam int BLOCK_BYTES = 64;
    localparam int HALF_ROUNDS = ((ROUNDS + 1) / 2) * 2;
    localparam int HALF_W      = $clog2(HALF_ROUNDS);
    localparam int OFFSET_W    = $clog2(BLOCK_BYTES);
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_0_7       = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_8_15      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_16_23     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_24_31     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_NONCE         = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FIRST_BLOCK   = 3'd5;

    localparam logic [31:0] SIGMA0 = 32'h6170_7865;
    localparam logic [31:0] SIGMA1 = 32'h3320_646e;
    localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
    localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

    localparam int ROT_B = 7;
    localparam int ROT_C = 9;
    localparam int ROT_D = 13;
    localparam int ROT_A = 18;

    typedef logic [15:0][31:0] block_t;

    typedef struct packed {
        logic [63:0] key_0_7;
        logic [63:0] key_8_15;
        logic [63:0] key_16_23;
        logic [63:0] key_24_31;
        logic [63:0] nonce;
        logic [63:0] first_block;
    } salsa_cfg_t;

    typedef struct packed {
        logic [7:0]          data;
        logic [OFFSET_W-1:0] offset;
        logic [63:0]         block;
        logic                wrapped;
        logic                gen;
    } salsa_entry_t;

    typedef struct packed {
        logic start;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [3:0] col_index(input int q, input int k);
        col_index = 4'(5 * q + 4 * k);
    endfunction

    function automatic block_t init_block(input salsa_cfg_t cfg, input logic [63:0] blk);
        block_t w;
        w[0]  = SIGMA0;
        w[1]  = cfg.key_0_7[31:0];
        w[2]  = cfg.key_0_7[63:32];
        w[3]  = cfg.key_8_15[31:0];
        w[4]  = cfg.key_8_15[63:32];
        w[5]  = SIGMA1;
        w[6]  = cfg.nonce[31:0];
        w[7]  = cfg.nonce[63:32];
        w[8]  = blk[31:0];
        w[9]  = blk[63:32];
        w[10] = SIGMA2;
        w[11] = cfg.key_16_23[31:0];
        w[12] = cfg.key_16_23[63:32];
        w[13] = cfg.key_24_31[31:0];
        w[14] = cfg.key_24_31[63:32];
        w[15] = SIGMA3;
        init_block = w;
    endfunction

    function automatic block_t transpose(input block_t w);
        block_t t;
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                t[4 * r + c] = w[4 * c + r];
            end
        end
        transpose = t;
    endfunction

endpackage

// ===== hw/rtl/salsa_in_if.sv =====
// Input channel of the Salsa20 stream cipher: one message word per handshake.
// Stands alone; no package needed.
interface salsa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] message_byte;
    logic       message_start;

    modport source (output valid, output message_byte, output message_start, input ready);
    modport sink (input valid, input message_byte, input message_start, output ready);
endinterface

// ===== hw/rtl/salsa_out_if.sv =====
// Output channel of the Salsa20 stream cipher: one result word per handshake.
// Stands alone; no package needed.
interface salsa_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] result_byte;
    logic       counter_wrapped;

    modport source (output valid, output result_byte, output counter_wrapped, input ready);
    modport sink (input valid, input result_byte, input counter_wrapped, output ready);
endinterface

// ===== hw/rtl/salsa_front.sv =====
// Front end: accepts input words, tracks byte offset, block number and wrap state.
// Depends on salsa_pkg and salsa_in_if.
module salsa_front (
    input  logic                   clk,
    input  logic                   rst_n,
    salsa_in_if.sink               in_ch,
    input  logic [63:0]            first_block,
    input  logic                   fifo_full,
    output logic                   push,
    output salsa_pkg::salsa_entry_t push_entry
);
    import salsa_pkg::*;

    logic [OFFSET_W-1:0] offset_reg, offset_next;
    logic [63:0]         block_reg, block_next;
    logic                wrapped_reg, wrapped_next;

    logic [OFFSET_W-1:0] off;
    logic [OFFSET_W-1:0] off_inc;
    logic [63:0]         blk;
    logic                wr;

    assign in_ch.ready = !fifo_full;
    assign push        = in_ch.valid && !fifo_full;

    always_comb
    begin
        off     = in_ch.message_start ? '0 : offset_reg;
        blk     = in_ch.message_start ? first_block : block_reg;
        wr      = in_ch.message_start ? 1'b0 : wrapped_reg;
        off_inc = off + 1'b1;

        push_entry.data    = in_ch.message_byte;
        push_entry.offset  = off;
        push_entry.block   = blk;
        push_entry.wrapped = wr;
        push_entry.gen     = (off == '0) && !wr;

        offset_next  = offset_reg;
        block_next   = block_reg;
        wrapped_next = wrapped_reg;
        if (push)
        begin
            offset_next  = off_inc;
            block_next   = blk;
            wrapped_next = wr;
            if (off_inc == '0)
            begin
                if (!wr && (blk == '1))
                begin
                    wrapped_next = 1'b1;
                end
                block_next = blk + 64'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg  <= '0;
            block_reg   <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            offset_reg  <= offset_next;
            block_reg   <= block_next;
            wrapped_reg <= wrapped_next;
        end
    end
endmodule

// ===== hw/rtl/salsa_fifo.sv =====
// Short queue of classified words between the front end and the back end.
// Depends on salsa_pkg.
module salsa_fifo (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  salsa_pkg::salsa_entry_t push_entry,
    output logic                    full,
    input  logic                    pop,
    output salsa_pkg::salsa_entry_t head,
    output logic                    head_valid
);
    import salsa_pkg::*;

    salsa_entry_t            entries_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0]   count_reg, count_next;

    assign full       = (count_reg == FIFO_CNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

// ===== hw/rtl/salsa_core.sv =====
// Iterative Salsa20 block function: one quarter-round step on all four columns a cycle.
// The matrix is transposed after each half round. Depends on salsa_pkg.
module salsa_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  salsa_pkg::core_ctrl_t ctrl,
    input  salsa_pkg::salsa_cfg_t cfg,
    input  logic [63:0]           block_number,
    output salsa_pkg::core_stat_t stat,
    output salsa_pkg::block_t     keystream
);
    import salsa_pkg::*;

    localparam logic [1:0] CORE_IDLE  = 2'd0;
    localparam logic [1:0] CORE_ROUND = 2'd1;
    localparam logic [1:0] CORE_FINAL = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [1:0]        step_reg, step_next;
    logic [HALF_W-1:0] half_reg, half_next;
    block_t            words_reg, words_next;

    block_t init;
    block_t stepped;

    assign init = init_block(cfg, block_number);

    always_comb
    begin
        stepped = words_reg;
        for (int q = 0; q < 4; q++)
        begin
            case (step_reg)
                2'd0:
                begin
                    stepped[col_index(q, 1)] = words_reg[col_index(q, 1)]
                        ^ rotl(words_reg[col_index(q, 0)] + words_reg[col_index(q, 3)], ROT_B);
                end
                2'd1:
                begin
                    stepped[col_index(q, 2)] = words_reg[col_index(q, 2)]
                        ^ rotl(words_reg[col_index(q, 1)] + words_reg[col_index(q, 0)], ROT_C);
                end
                2'd2:
                begin
                    stepped[col_index(q, 3)] = words_reg[col_index(q, 3)]
                        ^ rotl(words_reg[col_index(q, 2)] + words_reg[col_index(q, 1)], ROT_D);
                end
                default:
                begin
                    stepped[col_index(q, 0)] = words_reg[col_index(q, 0)]
                        ^ rotl(words_reg[col_index(q, 3)] + words_reg[col_index(q, 2)], ROT_A);
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        half_next  = half_reg;
        words_next = words_reg;
        for (int i = 0; i < 16; i++)
        begin
            keystream[i] = words_reg[i] + init[i];
        end
        stat.busy = (state_reg != CORE_IDLE);
        stat.done = (state_reg == CORE_FINAL);

        case (state_reg)
            CORE_IDLE:
            begin
                if (ctrl.start)
                begin
                    words_next = init;
                    step_next  = '0;
                    half_next  = '0;
                    state_next = CORE_ROUND;
                end
            end
            CORE_ROUND:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == 2'd3)
                begin
                    words_next = transpose(stepped);
                    if (half_reg == HALF_W'(HALF_ROUNDS - 1))
                    begin
                        state_next = CORE_FINAL;
                    end
                    else
                    begin
                        half_next = half_reg + 1'b1;
                    end
                end
                else
                begin
                    words_next = stepped;
                end
            end
            CORE_FINAL:
            begin
                state_next = CORE_IDLE;
            end
            default:
            begin
                state_next = CORE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        words_reg <= words_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CORE_IDLE;
            step_reg  <= '0;
            half_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            half_reg  <= half_next;
        end
    end
endmodule

// ===== hw/rtl/salsa_back.sv =====
// Back end: generates keystream blocks when needed and registers the result words.
// Depends on salsa_pkg, salsa_out_if and salsa_core.
module salsa_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  salsa_pkg::salsa_cfg_t   cfg,
    input  salsa_pkg::salsa_entry_t head,
    input  logic                    head_valid,
    output logic                    pop,
    salsa_out_if.source             out_ch
);
    import salsa_pkg::*;

    core_ctrl_t core_ctrl;
    core_stat_t core_stat;
    block_t     core_keystream;

    block_t     ks_reg, ks_next;
    logic       have_block_reg, have_block_next;
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_wrapped_reg, out_wrapped_next;

    logic       out_free;
    logic [31:0] ks_word;
    logic [7:0]  ks_byte;

    salsa_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (core_ctrl),
        .cfg          (cfg),
        .block_number (head.block),
        .stat         (core_stat),
        .keystream    (core_keystream)
    );

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.result_byte     = out_byte_reg;
    assign out_ch.counter_wrapped = out_wrapped_reg;

    assign out_free        = !out_valid_reg || out_ch.ready;
    assign core_ctrl.start = head_valid && head.gen && !have_block_reg && !core_stat.busy;
    assign pop             = head_valid && (!head.gen || have_block_reg) && out_free;
    assign ks_word         = ks_reg[head.offset[OFFSET_W-1:2]];
    assign ks_byte         = 8'(ks_word >> {head.offset[1:0], 3'b000});

    always_comb
    begin
        ks_next          = ks_reg;
        have_block_next  = have_block_reg;
        out_valid_next   = out_valid_reg;
        out_byte_next    = out_byte_reg;
        out_wrapped_next = out_wrapped_reg;

        if (core_stat.done)
        begin
            ks_next         = core_keystream;
            have_block_next = 1'b1;
        end

        if (pop)
        begin
            have_block_next  = 1'b0;
            out_valid_next   = 1'b1;
            out_byte_next    = head.wrapped ? 8'd0 : (head.data ^ ks_byte);
            out_wrapped_next = head.wrapped;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        ks_reg          <= ks_next;
        out_byte_reg    <= out_byte_next;
        out_wrapped_reg <= out_wrapped_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_block_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            have_block_reg <= have_block_next;
            out_valid_reg  <= out_valid_next;
        end
    end
endmodule

// ===== hw/rtl/salsa20_stream_cipher.sv =====
// Salsa20 stream cipher, one message word in and one result word out per handshake.
// A word that needs no new block passes the FIFO entry and the output register; one word a cycle
// while the output is not stalled and no new block is needed. The first word of each block, unless
// the counter has wrapped, waits for the block function run by the single iterative salsa_core unit.
// Reset clears the configuration registers, byte offset, block number and wrap state.
// Depends on salsa_pkg, both channel interfaces, salsa_front, salsa_fifo and salsa_back.
module salsa20_stream_cipher (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [salsa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [salsa_pkg::CFG_DATA_W-1:0]   cfg_data,
    salsa_in_if.sink                           in_ch,
    salsa_out_if.source                        out_ch
);
    import salsa_pkg::*;

    salsa_cfg_t   cfg_reg, cfg_next;
    salsa_entry_t push_entry;
    salsa_entry_t head;
    logic         push;
    logic         fifo_full;
    logic         pop;
    logic         head_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_KEY_0_7:     cfg_next.key_0_7     = cfg_data;
                CFG_KEY_8_15:    cfg_next.key_8_15    = cfg_data;
                CFG_KEY_16_23:   cfg_next.key_16_23   = cfg_data;
                CFG_KEY_24_31:   cfg_next.key_24_31   = cfg_data;
                CFG_NONCE:       cfg_next.nonce       = cfg_data;
                CFG_FIRST_BLOCK: cfg_next.first_block = cfg_data;
                default:         cfg_next             = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    salsa_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_ch       (in_ch),
        .first_block (cfg_reg.first_block),
        .fifo_full   (fifo_full),
        .push        (push),
        .push_entry  (push_entry)
    );

    salsa_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (fifo_full),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid)
    );

    salsa_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .out_ch     (out_ch)
    );
endmodule
